[rtl/mra_pkg.sv]
// Package for the modular residue ALU: operation codes, controller states, command and status
// structs. Used by every module of the block.
package mra_pkg;
    localparam int W = 32;

    typedef enum logic [2:0] {
        K_ADD = 3'd0, K_SUB = 3'd1, K_MUL = 3'd2, K_NEG = 3'd3,
        K_INV = 3'd4, K_DIV = 3'd5, K_CMP = 3'd6, K_NONE = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_REDA, S_REDB, S_EXEC, S_EU_DIV, S_EU_MUL, S_EU_UPD,
        S_EU_END, S_DMUL, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        C_NOP, C_LOAD, C_DIV_START, C_DIV_STEP, C_MUL_START, C_MUL_STEP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic       iter_done;
        logic       iter_last;
        logic       r1_zero;
        logic       r0_one;
    } t_stat;

    localparam logic [1:0] SEL_A   = 2'd0;
    localparam logic [1:0] SEL_B   = 2'd1;
    localparam logic [1:0] SEL_EU  = 2'd2;
    localparam logic [1:0] SEL_DIV = 2'd3;
endpackage

[rtl/mra_datapath.sv]
// Datapath of the modular residue ALU: operand registers, a shift-subtract divider and a
// double-and-add modular multiplier. Depends on mra_pkg.
module mra_datapath import mra_pkg::*; (
    input  logic         i_clk,
    input  logic [W-1:0] i_mod,
    input  logic [2:0]   i_kind,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    output logic [W-1:0] o_result,
    output logic         o_eq,
    output logic         o_lt
);
    logic [W-1:0] r_m, r_a, r_b, r_r0, r_r1, r_t0, r_t1, r_q;
    logic [W-1:0] r_rem, r_quo, r_dv, r_acc, r_ma, r_mb;
    logic [W:0]   r_dn;
    logic [5:0]   r_cnt;
    logic [2:0]   r_kind;
    logic [W:0]   w_sh;
    logic [W-1:0] w_dbl, w_s2, w_s3;

    assign o_stat.iter_done = (r_cnt == 6'd0);
    assign o_stat.iter_last = (r_cnt == 6'd1);
    assign o_stat.r1_zero   = (r_r1 == '0);
    assign o_stat.r0_one    = (r_r0 == W'(1));
    assign o_eq = (r_a == r_b);
    assign o_lt = (r_a < r_b);

    always_comb begin
        w_sh  = {r_rem, r_quo[W-1]};
        w_dbl = (r_acc >= r_m - r_acc) ? r_acc - (r_m - r_acc) : r_acc + r_acc;
        w_s2  = w_dbl;
        w_s3  = (w_dbl >= r_m - r_ma) ? w_dbl - (r_m - r_ma) : w_dbl + r_ma;
        case (r_kind)
            K_ADD:   o_result = (r_a >= r_m - r_b) ? r_a - (r_m - r_b) : r_a + r_b;
            K_SUB:   o_result = (r_a >= r_b) ? r_a - r_b : r_a + (r_m - r_b);
            K_NEG:   o_result = (r_a == '0) ? '0 : r_m - r_a;
            K_MUL, K_DIV: o_result = r_acc;
            K_INV:   o_result = r_t0;
            default: o_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            C_LOAD: begin
                r_m    <= (i_mod == '0) ? W'(1) : i_mod;
                r_kind <= i_kind;
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= '0;
            end
            C_DIV_START: begin
                r_rem <= '0;
                r_cnt <= (i_cmd.sel == SEL_EU) ? 6'd0 : 6'(W);
                case (i_cmd.sel)
                    SEL_A:   begin r_quo <= r_a;  r_dn <= {1'b0, r_m}; end
                    SEL_B:   begin r_quo <= r_b;  r_dn <= {1'b0, r_m}; end
                    default: begin r_quo <= r_r0; r_dn <= {1'b0, r_r1}; end
                endcase
                if (i_cmd.sel == SEL_EU) begin
                    r_r0 <= r_m;
                    r_r1 <= (r_kind == K_DIV) ? r_b : r_a;
                    r_t0 <= '0;
                    r_t1 <= (r_m == W'(1)) ? '0 : W'(1);
                end
            end
            C_DIV_STEP: begin
                r_cnt <= r_cnt - 6'd1;
                if (w_sh >= r_dn) begin
                    r_rem <= W'(w_sh - r_dn);
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                if (r_cnt == 6'd1) begin
                    if (i_cmd.sel == SEL_A) r_a <= (w_sh >= r_dn) ? W'(w_sh - r_dn)
                                                                  : w_sh[W-1:0];
                    if (i_cmd.sel == SEL_B) r_b <= (w_sh >= r_dn) ? W'(w_sh - r_dn)
                                                                  : w_sh[W-1:0];
                end
            end
            C_MUL_START: begin
                r_acc <= '0;
                r_cnt <= (i_cmd.sel == SEL_DIV) ? 6'd0 : 6'(W);
                case (i_cmd.sel)
                    SEL_A: begin r_ma <= r_a; r_mb <= r_b; end
                    SEL_B: begin r_ma <= r_a; r_mb <= r_t0; end
                    SEL_EU: begin
                        r_ma <= r_t1;
                        r_mb <= (r_quo >= r_m) ? r_quo - r_m : r_quo;
                        r_q  <= r_rem;
                    end
                    default: begin
                        r_r0 <= r_r1;
                        r_r1 <= r_q;
                        r_t0 <= r_t1;
                        r_t1 <= (r_dv >= r_acc) ? r_dv - r_acc : r_dv + (r_m - r_acc);
                    end
                endcase
                if (i_cmd.sel == SEL_EU) r_dv <= r_t0;
            end
            C_MUL_STEP: begin
                r_cnt <= r_cnt - 6'd1;
                r_mb  <= {r_mb[W-2:0], 1'b0};
                r_acc <= r_mb[W-1] ? w_s3 : w_s2;
            end
            default: ;
        endcase
    end
endmodule

[rtl/mra_ctrl.sv]
// Controller state machine of the modular residue ALU. Sequences reduction, Euclid and
// multiplication in the datapath. Depends on mra_pkg.
module mra_ctrl import mra_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  logic [2:0] i_kind,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_noinv
);
    t_state r_st, n_st;
    logic [2:0] r_kind;
    logic r_noinv, n_noinv;

    assign o_noinv = r_noinv;

    always_comb begin
        n_st = r_st;
        n_noinv = r_noinv;
        case (r_st)
            S_IDLE:  if (i_in_valid) n_st = S_REDA;
            S_REDA:  if (i_stat.iter_last && o_cmd.op == C_DIV_STEP) n_st = S_REDB;
            S_REDB:  if (i_stat.iter_last && o_cmd.op == C_DIV_STEP) n_st = S_EXEC;
            S_EXEC: begin
                n_noinv = 1'b0;
                if (r_kind == K_INV || r_kind == K_DIV) n_st = S_EU_DIV;
                else if (r_kind == K_MUL) n_st = S_DMUL;
                else n_st = S_DONE;
            end
            S_EU_DIV: if (i_stat.r1_zero && o_cmd.op == C_DIV_START) n_st = S_EU_END;
                      else if (i_stat.iter_last && o_cmd.op == C_DIV_STEP) n_st = S_EU_MUL;
            S_EU_MUL: if (i_stat.iter_last && o_cmd.op == C_MUL_STEP) n_st = S_EU_UPD;
            S_EU_UPD: n_st = S_EU_DIV;
            S_EU_END: begin
                n_noinv = !i_stat.r0_one;
                n_st = (r_kind == K_DIV && i_stat.r0_one) ? S_DMUL : S_DONE;
            end
            S_DMUL:  if (i_stat.iter_last && o_cmd.op == C_MUL_STEP) n_st = S_DONE;
            S_DONE:  if (i_out_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_st == S_IDLE);
        o_out_valid = (r_st == S_DONE);
        o_cmd.op  = C_NOP;
        o_cmd.sel = SEL_A;
        case (r_st)
            S_IDLE: if (i_in_valid) o_cmd.op = C_LOAD;
            S_REDA: begin
                o_cmd.sel = SEL_A;
                o_cmd.op  = i_stat.iter_done ? C_DIV_START : C_DIV_STEP;
            end
            S_REDB: begin
                o_cmd.sel = SEL_B;
                o_cmd.op  = i_stat.iter_done ? C_DIV_START : C_DIV_STEP;
            end
            S_EXEC: begin
                o_cmd.sel = (r_kind == K_MUL) ? SEL_A : SEL_EU;
                o_cmd.op  = (r_kind == K_MUL) ? C_MUL_START : C_DIV_START;
                if (r_kind != K_MUL && r_kind != K_INV && r_kind != K_DIV) o_cmd.op = C_NOP;
            end
            S_EU_DIV: begin
                o_cmd.sel = SEL_DIV;
                o_cmd.op  = i_stat.iter_done ? C_DIV_START : C_DIV_STEP;
            end
            S_EU_MUL: begin
                o_cmd.sel = SEL_EU;
                o_cmd.op  = i_stat.iter_done ? C_MUL_START : C_MUL_STEP;
            end
            S_EU_UPD: begin
                o_cmd.sel = SEL_DIV;
                o_cmd.op  = C_MUL_START;
            end
            S_EU_END: if (r_kind == K_DIV && i_stat.r0_one) begin
                o_cmd.sel = SEL_B;
                o_cmd.op  = C_MUL_START;
            end
            S_DMUL:  o_cmd.op = C_MUL_STEP;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_noinv <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_noinv <= n_noinv;
        end
        if (r_st == S_IDLE && i_in_valid) r_kind <= i_kind;
    end
endmodule

[rtl/modular_residue_alu_top.sv]
// Top level of the modular residue ALU: modulus register, controller and datapath.
// Depends on mra_pkg, mra_ctrl and mra_datapath.
// Sequence: two 32-step reductions, then per Euclid round a 32-step divide and a 32-step
// multiply. One request is in flight at a time, as the divider and multiplier are shared.
// Synchronous active-low reset sets the modulus to 1.
module modular_residue_alu_top import mra_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [W-1:0] i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [2:0]   i_kind,
    input  logic [W-1:0] i_operand_a,
    input  logic [W-1:0] i_operand_b,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [W-1:0] o_result,
    output logic         o_is_equal,
    output logic         o_is_less,
    output logic         o_no_inverse
);
    logic [W-1:0] r_mod, w_res;
    logic [2:0]   r_kind;
    logic         w_eq, w_lt, w_ni;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mod <= W'(1);
        else if (i_cfg_valid) r_mod <= i_cfg_data;
        if (i_in_valid && o_in_ready) r_kind <= i_kind;
    end

    mra_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_kind, .i_stat(w_stat), .o_cmd(w_cmd), .o_noinv(w_ni)
    );

    mra_datapath u_dp (
        .i_clk, .i_mod(r_mod), .i_kind, .i_a(i_operand_a), .i_b(i_operand_b),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_result(w_res), .o_eq(w_eq), .o_lt(w_lt)
    );

    always_comb begin
        o_result     = (r_kind == K_INV || r_kind == K_DIV) && w_ni ? '0 : w_res;
        o_is_equal   = (r_kind == K_CMP) && w_eq;
        o_is_less    = (r_kind == K_CMP) && w_lt;
        o_no_inverse = (r_kind == K_INV || r_kind == K_DIV) && w_ni;
    end
endmodule

[rtl/mra_checker.sv]
// Port-level checker for the modular residue ALU, bound to the top level.
// Depends on mra_pkg.
module mra_checker import mra_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_in_ready,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] o_result,
    input logic         o_is_equal,
    input logic         o_is_less,
    input logic         o_no_inverse
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready during result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("result dropped");
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_equal && o_is_less)) else $error("eq and lt");
    a_ni: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_inverse |-> o_result == '0) else $error("noinv result");
endmodule

bind modular_residue_alu_top mra_checker u_chk (.*);

[tb/sv/testbench.sv]
// Testbench for modular_residue_alu_top: a queue-fed driver, a monitor that predicts each
// accepted request and checks results in order. Depends on mra_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import mra_pkg::*;

    localparam int LIMIT_CYCLES = 30000000;
    localparam int NUM_PHASES = 12;

    typedef struct {
        logic [2:0]   kind;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } t_request;

    typedef struct {
        logic [W-1:0] result;
        logic         is_equal;
        logic         is_less;
        logic         no_inverse;
    } t_residue;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [W-1:0] i_cfg_data = '0;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    logic [2:0]   i_kind = '0;
    logic [W-1:0] i_operand_a = '0;
    logic [W-1:0] i_operand_b = '0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    logic [W-1:0] o_result;
    logic         o_is_equal;
    logic         o_is_less;
    logic         o_no_inverse;

    t_request pending_requests[$];
    t_residue expected_residues[$];
    logic [W-1:0] modulus_shadow = 32'd1;
    int idle_mode = 0;
    int mismatches = 0;
    int cycles = 0;

    modular_residue_alu_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_kind(i_kind),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_result(o_result),
        .o_is_equal(o_is_equal), .o_is_less(o_is_less), .o_no_inverse(o_no_inverse)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic find_inverse(input logic [63:0] x, input logic [63:0] m,
                                          output logic [63:0] inv);
        longint unsigned r0, r1, q, nr;
        longint t0, t1, nt;
        r0 = m;
        r1 = x;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            nr = r0 - q * r1;
            nt = t0 - longint'(q) * t1;
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        if (r0 == 1) begin
            if (t0 < 0) t0 = t0 + longint'(m);
            inv = longint'(t0) % longint'(m);
            return 1'b1;
        end
        inv = '0;
        return 1'b0;
    endfunction

    function automatic t_residue compute_residue(input t_request req, input logic [W-1:0] reg_m);
        t_residue r;
        logic [63:0] m, a, b, inv;
        m = (reg_m == 0) ? 64'd1 : {32'd0, reg_m};
        a = {32'd0, req.a} % m;
        b = {32'd0, req.b} % m;
        r = '{default: '0};
        case (t_kind'(req.kind))
            K_ADD: r.result = W'((a + b) % m);
            K_SUB: r.result = W'((a + m - b) % m);
            K_MUL: r.result = W'((a * b) % m);
            K_NEG: r.result = W'((m - a) % m);
            K_INV: begin
                if (find_inverse(a, m, inv)) r.result = W'(inv);
                else r.no_inverse = 1'b1;
            end
            K_DIV: begin
                if (find_inverse(b, m, inv)) r.result = W'((a * inv) % m);
                else r.no_inverse = 1'b1;
            end
            K_CMP: begin
                r.is_equal = (a == b);
                r.is_less = (a < b);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] pick_operand(input logic [W-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return m - 1;
            2: return '1;
            3: return m;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic sender_gap();
        case (idle_mode)
            0: return $urandom_range(0, 99) < 15;
            1: return $urandom_range(0, 99) < 80;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_ready();
        case (idle_mode)
            0: return $urandom_range(0, 99) >= 80;
            1: return $urandom_range(0, 99) >= 15;
            default: return 1'b1;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_ready) begin
        end else if (pending_requests.size() > 0 && !sender_gap()) begin
            t_request req;
            req = pending_requests.pop_front();
            i_in_valid <= 1'b1;
            i_kind <= req.kind;
            i_operand_a <= req.a;
            i_operand_b <= req.b;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= receiver_ready();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) modulus_shadow = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                t_request req;
                req = '{kind: i_kind, a: i_operand_a, b: i_operand_b};
                expected_residues.push_back(compute_residue(req, modulus_shadow));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_residues.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", o_result);
                end else begin
                    t_residue e;
                    e = expected_residues.pop_front();
                    if (o_result !== e.result || o_is_equal !== e.is_equal ||
                        o_is_less !== e.is_less || o_no_inverse !== e.no_inverse) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h eq%b lt%b ni%b, got %h eq%b lt%b ni%b",
                                     e.result, e.is_equal, e.is_less, e.no_inverse,
                                     o_result, o_is_equal, o_is_less, o_no_inverse);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_modulus(input logic [W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_request(input logic [2:0] kind, input logic [W-1:0] a,
                               input logic [W-1:0] b);
        pending_requests.push_back('{kind: kind, a: a, b: b});
    endtask

    initial begin
        logic [W-1:0] moduli[NUM_PHASES];
        logic [W-1:0] m;
        moduli = '{32'hFFFF_FFFB, 32'd12, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd2,
                   32'h8000_0000, 32'd97, 32'd0, 32'd65536, 32'd0, 32'd0};
        moduli[8] = $urandom_range(3, 1000);
        moduli[10] = $urandom | 32'd1;
        moduli[11] = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_mode = (p * 3) / NUM_PHASES;
            m = moduli[p];
            write_modulus(m);
            if (p == 0) begin
                for (int k = 0; k < 8; k++) begin
                    add_request(k[2:0], '1, m - 1);
                    add_request(k[2:0], '0, 32'd1);
                end
            end else if (p == 1) begin
                add_request(K_INV, 32'd4, '0);
                add_request(K_DIV, 32'd5, 32'd6);
                add_request(K_INV, 32'd5, '1);
            end
            for (int i = 0; i < 100; i++)
                add_request(3'($urandom_range(0, 7)), pick_operand(m), pick_operand(m));
            while (pending_requests.size() > 0 || i_in_valid || expected_residues.size() > 0)
                @(posedge i_clk);
            repeat (20) @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_residues.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
